@@ hw/rtl/assert_macros.svh @@
// assertion macros shared by the circle coverage mask rtl
// clocked implication checks with an active-low reset disable
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/ccm_pkg.sv @@
// shared types and constants for the circle coverage mask pipeline
// no dependencies
`default_nettype none

package ccm_pkg;

    localparam int MAX_RADIUS  = 32;
    localparam int FULL_COVER  = 15;
    localparam int RAD_W       = 6;
    localparam int COORD_W     = 6;
    localparam int OPAC_W      = 4;
    localparam int ALPHA_W     = 4;
    localparam int IDX_W       = 11;
    localparam int REM_W       = 14;
    localparam int DSOR_W      = 10;
    localparam int Q_W         = 5;
    localparam int DIV_STEPS   = 5;
    localparam int DIV15_MUL   = 137;
    localparam int DIV15_SHIFT = 11;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 6;

    localparam logic [CFG_IDX_W-1:0] REG_RADIUS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OPACITY = 2'd1;

    typedef struct packed {
        logic [IDX_W-1:0] byte_index;
        logic             high_half;
    } side_t;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [DSOR_W-1:0] dsor;
        logic [Q_W-1:0]    q;
        side_t             side;
    } div_beat_t;

endpackage

`default_nettype wire

@@ hw/rtl/ccm_geom.sv @@
// offset, square and raw coverage stages of the mask pipeline
// depends on ccm_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module ccm_geom (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [5:0]                radius,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [5:0]                pixel_column,
    input  logic [5:0]                pixel_row,
    output logic                      out_valid,
    input  logic                      out_ready,
    output ccm_pkg::div_beat_t        out_beat
);
    import ccm_pkg::*;

    logic               v1_reg, v2_reg, v3_reg;
    logic               rdy1, rdy2, rdy3;

    logic [RAD_W-1:0]   r1_next, r1_reg, r2_reg;
    logic signed [8:0]  dx1_next, dx1_reg, dy1_next, dy1_reg;
    logic [11:0]        rr1;
    logic [12:0]        edge1_next, edge1_reg, edge2_reg;
    logic [12:0]        lin1;
    side_t              side1_next, side1_reg, side2_reg;

    logic signed [17:0] dxw, dyw, sqx_full, sqy_full;
    logic [13:0]        sqx2_next, sqx2_reg, sqy2_next, sqy2_reg;

    logic signed [16:0] c3;
    logic               pos3;
    div_beat_t          beat3_next, beat3_reg;

    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // stage 1: effective radius, half-pixel offsets, edge, byte index
    always_comb
    begin
        priority if (radius == '0)
            r1_next = RAD_W'(1);
        else if (radius > RAD_W'(MAX_RADIUS))
            r1_next = RAD_W'(MAX_RADIUS);
        else
            r1_next = radius;
        dx1_next   = $signed({2'b00, pixel_column, 1'b1}) - $signed({2'b00, r1_next, 1'b0});
        dy1_next   = $signed({2'b00, pixel_row, 1'b1}) - $signed({2'b00, r1_next, 1'b0});
        rr1        = {6'b0, r1_next} * ({6'b0, r1_next} + 12'd1);
        edge1_next = {rr1[10:0], 2'b00};
        lin1       = ({7'b0, pixel_row} * {6'b0, r1_next, 1'b0}) + {7'b0, pixel_column};
        side1_next.byte_index = lin1[IDX_W:1];
        side1_next.high_half  = pixel_column[0];
    end

    // stage 2: squares
    always_comb
    begin
        dxw       = 18'(dx1_reg);
        dyw       = 18'(dy1_reg);
        sqx_full  = dxw * dxw;
        sqy_full  = dyw * dyw;
        sqx2_next = sqx_full[13:0];
        sqy2_next = sqy_full[13:0];
    end

    // stage 3: raw coverage and rounded dividend
    always_comb
    begin
        c3 = $signed({4'b0, edge2_reg}) - $signed({3'b0, sqx2_reg})
           - $signed({3'b0, sqy2_reg});
        pos3 = !c3[16] && (c3 != '0);
        beat3_next.rem  = pos3 ? ({c3[12:0], 1'b0} + REM_W'(r2_reg[RAD_W-1:1])) : '0;
        beat3_next.dsor = {r2_reg, 4'b0000};
        beat3_next.q    = '0;
        beat3_next.side = side2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= in_valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            r1_reg    <= r1_next;
            dx1_reg   <= dx1_next;
            dy1_reg   <= dy1_next;
            edge1_reg <= edge1_next;
            side1_reg <= side1_next;
        end
        if (rdy2 && v1_reg)
        begin
            r2_reg    <= r1_reg;
            edge2_reg <= edge1_reg;
            side2_reg <= side1_reg;
            sqx2_reg  <= sqx2_next;
            sqy2_reg  <= sqy2_next;
        end
        if (rdy3 && v2_reg)
            beat3_reg <= beat3_next;
    end

    assign out_valid = v3_reg;
    assign out_beat  = beat3_reg;

    `ASSERT_IMPL(a_radius_range, clk, rst_n, v1_reg,
        (r1_reg != '0) && (r1_reg <= RAD_W'(MAX_RADIUS)), "effective radius out of range")
    `ASSERT_IMPL(a_dsor_form, clk, rst_n, v3_reg,
        (beat3_reg.dsor[3:0] == 4'b0000) && (beat3_reg.dsor != '0), "bad initial divisor")

endmodule

`default_nettype wire

@@ hw/rtl/ccm_div_step.sv @@
// one restoring division step of the coverage quotient, one register stage
// depends on ccm_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module ccm_div_step (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ccm_pkg::div_beat_t in_beat,
    output logic               out_valid,
    input  logic               out_ready,
    output ccm_pkg::div_beat_t out_beat
);
    import ccm_pkg::*;

    logic      valid_reg;
    logic      ge;
    div_beat_t beat_next, beat_reg;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        ge             = in_beat.rem >= {4'b0, in_beat.dsor};
        beat_next.rem  = ge ? (in_beat.rem - {4'b0, in_beat.dsor}) : in_beat.rem;
        beat_next.dsor = in_beat.dsor >> 1;
        beat_next.q    = {in_beat.q[Q_W-2:0], ge};
        beat_next.side = in_beat.side;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            beat_reg <= beat_next;
    end

    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

    `ASSERT_NEXT(a_stall_hold, clk, rst_n, valid_reg && !out_ready,
        valid_reg && $stable(beat_reg), "division stage lost or changed a stalled beat")

endmodule

`default_nettype wire

@@ hw/rtl/ccm_scale.sv @@
// clamp, opacity scaling and inversion stages of the mask pipeline
// depends on ccm_pkg
`default_nettype none

module ccm_scale (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [3:0]                  opacity,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  ccm_pkg::div_beat_t          in_beat,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [3:0]                  alpha_nibble,
    output ccm_pkg::side_t              side
);
    import ccm_pkg::*;

    logic               va_reg, vb_reg;
    logic               rdy_a, rdy_b;
    logic [ALPHA_W-1:0] cov_a;
    logic [7:0]         prod_a_next, prod_a_reg;
    side_t              side_a_reg, side_b_reg;
    logic [15:0]        mul_b;
    logic [ALPHA_W-1:0] alpha_b_next, alpha_b_reg;

    assign rdy_b    = !vb_reg || out_ready;
    assign rdy_a    = !va_reg || rdy_b;
    assign in_ready = rdy_a;

    always_comb
    begin
        cov_a       = in_beat.q[Q_W-1] ? ALPHA_W'(FULL_COVER) : in_beat.q[ALPHA_W-1:0];
        prod_a_next = ({4'b0, cov_a} * {4'b0, opacity}) + 8'(FULL_COVER / 2);
    end

    // divide by 15 through a reciprocal multiply
    always_comb
    begin
        mul_b        = {8'b0, prod_a_reg} * 16'(DIV15_MUL);
        alpha_b_next = ALPHA_W'(FULL_COVER) - mul_b[DIV15_SHIFT +: ALPHA_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            if (rdy_a)
                va_reg <= in_valid;
            if (rdy_b)
                vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy_a && in_valid)
        begin
            prod_a_reg <= prod_a_next;
            side_a_reg <= in_beat.side;
        end
        if (rdy_b && va_reg)
        begin
            alpha_b_reg <= alpha_b_next;
            side_b_reg  <= side_a_reg;
        end
    end

    assign out_valid    = vb_reg;
    assign alpha_nibble = alpha_b_reg;
    assign side         = side_b_reg;

endmodule

`default_nettype wire

@@ hw/rtl/circle_coverage_mask_pixel.sv @@
// throughput: one pixel per cycle while m_axis_tready is not stalling, set by the fully pipelined datapath
// (3 geometry stages, 5 quotient stages, 2 scaling stages)
// each stage holds its beat under stall while earlier stages keep filling
// reset: pipeline empties, radius returns to 1 and opacity to 15
`default_nettype none

module circle_coverage_mask_pixel (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [5:0]  cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // pixel_column[5:0], pixel_row[11:6], zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // alpha_nibble[3:0], byte_index[14:4], zero pad
    output logic        m_axis_tuser    // high_half
);
    import ccm_pkg::*;

    logic [RAD_W-1:0]  radius_reg;
    logic [OPAC_W-1:0] opacity_reg;

    div_beat_t         step_beat  [0:DIV_STEPS];
    logic              step_valid [0:DIV_STEPS];
    logic              step_ready [0:DIV_STEPS];

    logic [ALPHA_W-1:0] alpha_nibble;
    side_t              side;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg  <= RAD_W'(1);
            opacity_reg <= OPAC_W'(FULL_COVER);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_RADIUS:  radius_reg  <= cfg_data[RAD_W-1:0];
                REG_OPACITY: opacity_reg <= cfg_data[OPAC_W-1:0];
                default:     ;
            endcase
        end
    end

    ccm_geom u_geom (
        .clk          (clk),
        .rst_n        (rst_n),
        .radius       (radius_reg),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .pixel_column (s_axis_tdata[5:0]),
        .pixel_row    (s_axis_tdata[11:6]),
        .out_valid    (step_valid[0]),
        .out_ready    (step_ready[0]),
        .out_beat     (step_beat[0])
    );

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        ccm_div_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (step_valid[k]),
            .in_ready  (step_ready[k]),
            .in_beat   (step_beat[k]),
            .out_valid (step_valid[k+1]),
            .out_ready (step_ready[k+1]),
            .out_beat  (step_beat[k+1])
        );
    end

    ccm_scale u_scale (
        .clk          (clk),
        .rst_n        (rst_n),
        .opacity      (opacity_reg),
        .in_valid     (step_valid[DIV_STEPS]),
        .in_ready     (step_ready[DIV_STEPS]),
        .in_beat      (step_beat[DIV_STEPS]),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .alpha_nibble (alpha_nibble),
        .side         (side)
    );

    assign m_axis_tdata = {1'b0, side.byte_index, alpha_nibble};
    assign m_axis_tuser = side.high_half;

endmodule

`default_nettype wire
